// ----- rtl/core/priority_sorted_registry_assert.svh -----
// Assertion macros shared by the registry checker.
// No dependencies.
`ifndef PRIORITY_SORTED_REGISTRY_ASSERT_SVH
`define PRIORITY_SORTED_REGISTRY_ASSERT_SVH
`define PSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/psr_pkg.sv -----
// Shared types and codes for the priority sorted registry.
// No dependencies.
`default_nettype none
package psr_pkg;
    localparam logic [1:0] MODE_REG   = 2'd0;
    localparam logic [1:0] MODE_UNREG = 2'd1;
    localparam logic [1:0] MODE_EN    = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  priority_req;
        logic [31:0] evt_mask;
        logic [31:0] handler;
        logic [31:0] context_tag;
        logic [31:0] target_id;
        logic        enable;
        logic [5:0]  index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [3:0]  entry_priority;
        logic [31:0] entry_mask;
        logic        entry_enabled;
        logic [31:0] entry_handler;
        logic [31:0] entry_context;
        logic [6:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;
endpackage
`default_nettype wire

// ----- rtl/core/psr_ctrl.sv -----
// Controller: accepts a transaction, steps the datapath, holds the result.
// Depends on psr_pkg.
`default_nettype none
module psr_ctrl import psr_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_EXEC;
                S_EXEC: r_state <= S_HOLD;
                S_HOLD: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/psr_dp.sv -----
// Datapath: slot table with per-slot compare and shift, id counter.
// Depends on psr_pkg.
`default_nettype none
module psr_dp import psr_pkg::*; #(
    parameter int MAX_ENTRIES    = 16,
    parameter int PRIORITY_TIERS = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output t_rsp o_rsp
);
    localparam int IW = $clog2(MAX_ENTRIES);

    logic [31:0] r_ids [MAX_ENTRIES];
    logic [3:0]  r_pri [MAX_ENTRIES];
    logic [31:0] r_msk [MAX_ENTRIES];
    logic        r_ena [MAX_ENTRIES];
    logic [31:0] r_hnd [MAX_ENTRIES];
    logic [31:0] r_ctx [MAX_ENTRIES];
    logic [6:0]  r_cnt;
    logic [31:0] r_nid;
    t_req        r_req;
    t_rsp        r_rsp;
    t_rsp        n_rsp;

    logic [MAX_ENTRIES-1:0] live, gt, hit, ins_after, hit_before, del_at_or_after;
    logic [MAX_ENTRIES-1:0] hit_first;
    logic found, full, bad;
    logic [31:0] nid_inc;

    always_comb begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            live[k] = 7'(k) < r_cnt;
            gt[k]   = live[k] && (r_req.priority_req < r_pri[k]);
            hit[k]  = live[k] && (r_ids[k] == r_req.target_id);
        end
        ins_after[0] = 1'b0; hit_before[0] = 1'b0;
        for (int k = 1; k < MAX_ENTRIES; k++) begin
            ins_after[k]  = ins_after[k-1] | gt[k-1];
            hit_before[k] = hit_before[k-1] | hit[k-1];
        end
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            hit_first[k]       = hit[k] & ~hit_before[k];
            del_at_or_after[k] = hit_before[k] | hit[k];
        end
        found   = |hit;
        full    = r_cnt >= 7'(MAX_ENTRIES);
        bad     = (r_req.handler == 32'd0) || (32'(r_req.priority_req) >= 32'(PRIORITY_TIERS));
        nid_inc = (r_nid == 32'hFFFF_FFFF) ? 32'd1 : r_nid + 32'd1;
    end

    always_comb begin
        n_rsp = '0;
        n_rsp.entry_count = r_cnt;
        case (r_req.mode)
            MODE_REG: begin
                if (bad) begin
                    n_rsp.status = ST_INVALID;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status      = ST_OK;
                    n_rsp.result_id   = r_nid;
                    n_rsp.entry_count = r_cnt + 7'd1;
                end
            end
            MODE_UNREG: begin
                if (!found || r_req.target_id == 32'd0) begin
                    n_rsp.status = ST_NOT_FOUND;
                end else begin
                    n_rsp.status      = ST_OK;
                    n_rsp.entry_count = r_cnt - 7'd1;
                end
            end
            MODE_EN: begin
                n_rsp.status = found ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
                if (7'(r_req.index) >= r_cnt || 32'(r_req.index) >= 32'(MAX_ENTRIES)) begin
                    n_rsp.status = ST_NOT_FOUND;
                end else begin
                    n_rsp.status         = ST_OK;
                    n_rsp.result_id      = r_ids[r_req.index[IW-1:0]];
                    n_rsp.entry_priority = r_pri[r_req.index[IW-1:0]];
                    n_rsp.entry_mask     = r_msk[r_req.index[IW-1:0]];
                    n_rsp.entry_enabled  = r_ena[r_req.index[IW-1:0]];
                    n_rsp.entry_handler  = r_hnd[r_req.index[IW-1:0]];
                    n_rsp.entry_context  = r_ctx[r_req.index[IW-1:0]];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_nid <= 32'd1;
            r_rsp <= '0;
            for (int k = 0; k < MAX_ENTRIES; k++) begin
                r_ids[k] <= '0; r_pri[k] <= '0; r_msk[k] <= '0;
                r_ena[k] <= 1'b0; r_hnd[k] <= '0; r_ctx[k] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_rsp <= n_rsp;
            case (r_req.mode)
                MODE_REG: begin
                    if (!bad && !full) begin
                        for (int k = 1; k < MAX_ENTRIES; k++) begin
                            if (ins_after[k]) begin
                                r_ids[k] <= r_ids[k-1]; r_pri[k] <= r_pri[k-1];
                                r_msk[k] <= r_msk[k-1]; r_ena[k] <= r_ena[k-1];
                                r_hnd[k] <= r_hnd[k-1]; r_ctx[k] <= r_ctx[k-1];
                            end
                        end
                        for (int k = 0; k < MAX_ENTRIES; k++) begin
                            if ((gt[k] && !ins_after[k]) ||
                                (!ins_after[k] && 7'(k) == r_cnt)) begin
                                r_ids[k] <= r_nid; r_pri[k] <= r_req.priority_req;
                                r_msk[k] <= r_req.evt_mask; r_ena[k] <= 1'b1;
                                r_hnd[k] <= r_req.handler; r_ctx[k] <= r_req.context_tag;
                            end
                        end
                        r_cnt <= r_cnt + 7'd1;
                        r_nid <= nid_inc;
                    end
                end
                MODE_UNREG: begin
                    if (found && r_req.target_id != 32'd0) begin
                        for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
                            if (del_at_or_after[k]) begin
                                if (7'(k + 1) < r_cnt) begin
                                    r_ids[k] <= r_ids[k+1]; r_pri[k] <= r_pri[k+1];
                                    r_msk[k] <= r_msk[k+1]; r_ena[k] <= r_ena[k+1];
                                    r_hnd[k] <= r_hnd[k+1]; r_ctx[k] <= r_ctx[k+1];
                                end else begin
                                    r_ids[k] <= '0; r_pri[k] <= '0; r_msk[k] <= '0;
                                    r_ena[k] <= 1'b0; r_hnd[k] <= '0; r_ctx[k] <= '0;
                                end
                            end
                        end
                        if (del_at_or_after[MAX_ENTRIES-1]) begin
                            r_ids[MAX_ENTRIES-1] <= '0; r_pri[MAX_ENTRIES-1] <= '0;
                            r_msk[MAX_ENTRIES-1] <= '0; r_ena[MAX_ENTRIES-1] <= 1'b0;
                            r_hnd[MAX_ENTRIES-1] <= '0; r_ctx[MAX_ENTRIES-1] <= '0;
                        end
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                MODE_EN: begin
                    if (found) begin
                        for (int k = 0; k < MAX_ENTRIES; k++)
                            if (hit_first[k]) r_ena[k] <= r_req.enable;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

// ----- rtl/core/priority_sorted_registry.sv -----
// Priority sorted registry top level.
// Slave stream carries one request per transaction, master stream one result.
// A request accepted in S_IDLE is captured in the request register, runs in
// S_EXEC into the result register and is held in S_HOLD with tvalid high.
// Only one transaction is in flight: no new request is taken until the result
// is accepted; the datapath does a parallel per-slot compare and shift.
// s_axis_tdata (lowest bit up): mode, priority_req, evt_mask, handler,
// context_tag, target_id, enable, index, zero pad to 144 bits.
// m_axis_tdata (lowest bit up): status, result_id, entry_priority, entry_mask,
// entry_enabled, entry_handler, entry_context, entry_count, zero pad to 144.
// Reset empties the table and sets the next id to one.
// When the receiver stalls the result holds and no new request is taken.
// Depends on psr_pkg, psr_ctrl, psr_dp.
`default_nettype none
module priority_sorted_registry import psr_pkg::*; #(
    parameter int MAX_ENTRIES    = 16,
    parameter int PRIORITY_TIERS = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // mode, priority_req, evt_mask, handler, context_tag, target_id, enable, index
    input  wire  [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status, result_id, entry_priority, entry_mask, entry_enabled,
    // entry_handler, entry_context, entry_count
    output logic [143:0] m_axis_tdata
);
    t_cmd cmd;
    t_req req;
    t_rsp rsp;

    assign req.mode         = s_axis_tdata[1:0];
    assign req.priority_req = s_axis_tdata[5:2];
    assign req.evt_mask     = s_axis_tdata[37:6];
    assign req.handler      = s_axis_tdata[69:38];
    assign req.context_tag  = s_axis_tdata[101:70];
    assign req.target_id    = s_axis_tdata[133:102];
    assign req.enable       = s_axis_tdata[134];
    assign req.index        = s_axis_tdata[140:135];

    psr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd)
    );

    psr_dp #(.MAX_ENTRIES(MAX_ENTRIES), .PRIORITY_TIERS(PRIORITY_TIERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(req), .o_rsp(rsp)
    );

    assign m_axis_tdata = {2'd0, rsp.entry_count, rsp.entry_context, rsp.entry_handler,
                           rsp.entry_enabled, rsp.entry_mask, rsp.entry_priority,
                           rsp.result_id, rsp.status};
endmodule
`default_nettype wire

// ----- rtl/core/psr_checker.sv -----
// Port-level checker for the priority sorted registry, bound to the top level.
// Depends on priority_sorted_registry_assert.svh.
`default_nettype none
`include "priority_sorted_registry_assert.svh"
module psr_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [143:0] m_axis_tdata
);
    `PSR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PSR_ASSERT_IMPL(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `PSR_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)
    `PSR_ASSERT_IMPL(a_cnt, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[141:135] <= 7'd64)
endmodule
bind priority_sorted_registry psr_checker u_psr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
